FILE: sv/psg_three_tone_one_noise_top_assert.svh
// Assertion macros shared by the sound generator checker.
`ifndef PSG_THREE_TONE_ONE_NOISE_TOP_ASSERT_SVH
`define PSG_THREE_TONE_ONE_NOISE_TOP_ASSERT_SVH

// Same-cycle implication, masked while reset is high.
`define PSG_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, masked while reset is high.
`define PSG_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also holds across reset.
`define PSG_ASSERT_ALWAYS(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/psg_pkg.sv
// Shared types, register codes and volume table of the sound generator.
package psg_pkg;

  // Request kinds carried in tuser bit 0.
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  // Write port carried in tuser bit 1.
  localparam logic PORT_TONE   = 1'b0;
  localparam logic PORT_STEREO = 1'b1;

  typedef enum logic {
    OP_WRITE,
    OP_TICK
  } op_t;

  typedef struct packed {
    op_t        op;
    logic       latch;
    logic [7:0] data;
  } cmd_t;

  // Register codes.
  localparam logic [2:0] REG_TONE0_PERIOD = 3'd0;
  localparam logic [2:0] REG_TONE0_ATT    = 3'd1;
  localparam logic [2:0] REG_TONE1_PERIOD = 3'd2;
  localparam logic [2:0] REG_TONE1_ATT    = 3'd3;
  localparam logic [2:0] REG_TONE2_PERIOD = 3'd4;
  localparam logic [2:0] REG_TONE2_ATT    = 3'd5;
  localparam logic [2:0] REG_NOISE_CTRL   = 3'd6;
  localparam logic [2:0] REG_NOISE_ATT    = 3'd7;

  // Noise rate selector codes.
  localparam logic [1:0] NOISE_RATE_16  = 2'd0;
  localparam logic [1:0] NOISE_RATE_32  = 2'd1;
  localparam logic [1:0] NOISE_RATE_64  = 2'd2;
  localparam logic [1:0] NOISE_RATE_TONE2 = 2'd3;

  localparam logic [9:0] NOISE_PERIOD_16 = 10'd16;
  localparam logic [9:0] NOISE_PERIOD_32 = 10'd32;
  localparam logic [9:0] NOISE_PERIOD_64 = 10'd64;

  localparam logic [15:0] LFSR_SEED = 16'h8000;

  localparam int unsigned COUNT_STEP    = 2;
  localparam int unsigned LOUDEST_LEVEL = 4095;
  localparam int unsigned QUEUE_DEPTH   = 2;

  localparam int unsigned LEVEL_W      = 13;
  localparam int unsigned SAMPLE_W     = 14;
  localparam int unsigned SAMPLE_LIMIT = 16383;

  typedef logic [LEVEL_W-1:0] level_t;
  typedef level_t level_table_t [16];

  // 65536 * 10^(-a/10), 2 dB per step.
  localparam int unsigned ATT_Q16 [15] = '{
    65536, 52057, 41350, 32846, 26090, 20724, 16462, 13076,
    10387, 8250, 6554, 5206, 4135, 3285, 2609
  };

  function automatic level_table_t build_level_table(int unsigned loudest);
    level_table_t     tbl;
    longint unsigned  prod;
    for (int a = 0; a < 16; a++) begin
      if (a == 15) begin
        tbl[a] = '0;
      end else begin
        prod   = longint'(loudest) * longint'(ATT_Q16[a]) + 64'd32768;
        tbl[a] = LEVEL_W'(prod >> 16);
      end
    end
    return tbl;
  endfunction

  localparam level_table_t LEVEL_TABLE = build_level_table(LOUDEST_LEVEL);

  localparam int unsigned FULL_SUM   = 4 * int'(LEVEL_TABLE[0]);
  localparam int unsigned SAMPLE_MAX = (FULL_SUM > SAMPLE_LIMIT) ? SAMPLE_LIMIT : FULL_SUM;

endpackage

FILE: sv/psg_front.sv
// Input side: accepts items, drops stereo-port writes, builds queue commands.
module psg_front (
  input  logic              s_axis_tvalid,
  input  logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,
  input  logic [1:0]        s_axis_tuser,
  output logic              push,
  output psg_pkg::cmd_t     cmd
);

  logic is_tick;
  logic ignored;

  assign is_tick = (s_axis_tuser[0] == psg_pkg::REQ_TICK);
  // stereo mask writes have no effect here
  assign ignored = !is_tick && (s_axis_tuser[1] == psg_pkg::PORT_STEREO);

  assign push = s_axis_tvalid && s_axis_tready && !ignored;

  always_comb begin
    cmd.op    = is_tick ? psg_pkg::OP_TICK : psg_pkg::OP_WRITE;
    cmd.latch = s_axis_tdata[7];
    cmd.data  = s_axis_tdata;
  end

endmodule

FILE: sv/psg_queue.sv
// Small first-word-fall-through command queue between front and back.
module psg_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  psg_pkg::cmd_t push_cmd,
  input  logic          pop,
  output logic          full,
  output logic          head_valid,
  output psg_pkg::cmd_t head_cmd
);

  localparam int unsigned DEPTH = psg_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  psg_pkg::cmd_t    entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = entries[rd_ptr];

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= bump(wr_ptr);
      if (pop)  rd_ptr <= bump(rd_ptr);
      if (push && !pop)      count <= count + CNT_W'(1);
      else if (pop && !push) count <= count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_cmd;
  end

endmodule

FILE: sv/psg_back.sv
// Execution side: register file, tone and noise generators, mixer, output register.
module psg_back #(
  parameter int unsigned COUNT_STEP    = psg_pkg::COUNT_STEP,
  parameter int unsigned LOUDEST_LEVEL = psg_pkg::LOUDEST_LEVEL
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          head_valid,
  input  psg_pkg::cmd_t head_cmd,
  output logic          pop,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [15:0]   m_axis_tdata
);

  localparam logic signed [10:0] STEP = 11'(COUNT_STEP);
  localparam psg_pkg::level_table_t LEVELS = psg_pkg::build_level_table(LOUDEST_LEVEL);

  // generator state
  logic [2:0]         latched_reg, latched_reg_next;
  logic [9:0]         tone_period [3];
  logic [9:0]         tone_period_next [3];
  logic signed [10:0] tone_counter [3];
  logic signed [10:0] tone_counter_next [3];
  logic [2:0]         tone_high, tone_high_next;
  logic [3:0]         tone_att [3];
  logic [3:0]         tone_att_next [3];
  logic signed [10:0] noise_counter, noise_counter_next;
  logic [9:0]         noise_period, noise_period_next;
  logic [2:0]         noise_mode, noise_mode_next;
  logic               noise_phase, noise_phase_next;
  logic [15:0]        lfsr, lfsr_next;
  logic               noise_on, noise_on_next;
  logic [3:0]         noise_att, noise_att_next;

  // mixer stage
  logic                 mix_valid;
  psg_pkg::level_t      mix_level [4];
  logic                 out_ready;
  logic                 mix_ready;
  logic                 do_tick;
  logic [14:0]          mix_sum;
  logic [13:0]          sample;

  assign out_ready = !m_axis_tvalid || m_axis_tready;
  assign mix_ready = !mix_valid || out_ready;
  assign pop       = head_valid && ((head_cmd.op == psg_pkg::OP_WRITE) || mix_ready);
  assign do_tick   = pop && (head_cmd.op == psg_pkg::OP_TICK);

  always_comb begin
    logic [2:0]         sel;
    logic [1:0]         ch;
    logic [9:0]         old_period;
    logic [9:0]         new_period;
    logic signed [10:0] dec;
    logic               fb;

    latched_reg_next   = latched_reg;
    tone_period_next   = tone_period;
    tone_counter_next  = tone_counter;
    tone_high_next     = tone_high;
    tone_att_next      = tone_att;
    noise_counter_next = noise_counter;
    noise_period_next  = noise_period;
    noise_mode_next    = noise_mode;
    noise_phase_next   = noise_phase;
    lfsr_next          = lfsr;
    noise_on_next      = noise_on;
    noise_att_next     = noise_att;
    sel        = head_cmd.latch ? head_cmd.data[6:4] : latched_reg;
    ch         = sel[2:1];
    old_period = '0;
    new_period = '0;
    dec        = '0;
    fb         = 1'b0;

    if (do_tick) begin
      for (int i = 0; i < 3; i++) begin
        dec = tone_counter[i] - STEP;
        if (dec <= 11'sd0) begin
          tone_counter_next[i] = $signed({1'b0, tone_period[i]});
          tone_high_next[i]    = ~tone_high[i];
        end else begin
          tone_counter_next[i] = dec;
        end
      end
      dec = noise_counter - STEP;
      if (dec <= 11'sd0) begin
        noise_counter_next = $signed({1'b0, noise_period});
        noise_phase_next   = ~noise_phase;
        if (!noise_phase) begin
          noise_on_next = lfsr[0];
          fb            = noise_mode[2] ? (lfsr[0] ^ lfsr[3]) : lfsr[0];
          lfsr_next     = {fb, lfsr[15:1]};
        end
      end else begin
        noise_counter_next = dec;
      end
    end else if (pop) begin
      latched_reg_next = sel;
      for (int i = 0; i < 3; i++) begin
        if (ch == 2'(i)) old_period = tone_period[i];
      end
      new_period = head_cmd.latch ? {old_period[9:4], head_cmd.data[3:0]}
                                  : {head_cmd.data[5:0], old_period[3:0]};
      unique case (sel) inside
        psg_pkg::REG_TONE0_PERIOD, psg_pkg::REG_TONE1_PERIOD,
        psg_pkg::REG_TONE2_PERIOD: begin
          for (int i = 0; i < 3; i++) begin
            if (ch == 2'(i)) tone_period_next[i] = new_period;
          end
          if (sel == psg_pkg::REG_TONE2_PERIOD &&
              noise_mode[1:0] == psg_pkg::NOISE_RATE_TONE2) begin
            noise_period_next = new_period;
          end
        end
        psg_pkg::REG_NOISE_CTRL: begin
          noise_mode_next = head_cmd.data[2:0];
          lfsr_next       = psg_pkg::LFSR_SEED;
          noise_on_next   = 1'b0;
          unique case (head_cmd.data[1:0])
            psg_pkg::NOISE_RATE_16: noise_period_next = psg_pkg::NOISE_PERIOD_16;
            psg_pkg::NOISE_RATE_32: noise_period_next = psg_pkg::NOISE_PERIOD_32;
            psg_pkg::NOISE_RATE_64: noise_period_next = psg_pkg::NOISE_PERIOD_64;
            default:                noise_period_next = tone_period[2];
          endcase
        end
        psg_pkg::REG_NOISE_ATT: begin
          noise_att_next = head_cmd.data[3:0];
        end
        default: begin
          // tone attenuation registers
          for (int i = 0; i < 3; i++) begin
            if (ch == 2'(i)) tone_att_next[i] = head_cmd.data[3:0];
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      latched_reg   <= psg_pkg::REG_TONE1_ATT;
      tone_period   <= '{default: '0};
      tone_counter  <= '{default: '0};
      tone_high     <= '1;
      tone_att      <= '{default: 4'hF};
      noise_counter <= '0;
      noise_period  <= psg_pkg::NOISE_PERIOD_16;
      noise_mode    <= '0;
      noise_phase   <= 1'b1;
      lfsr          <= psg_pkg::LFSR_SEED;
      noise_on      <= 1'b0;
      noise_att     <= 4'hF;
    end else begin
      latched_reg   <= latched_reg_next;
      tone_period   <= tone_period_next;
      tone_counter  <= tone_counter_next;
      tone_high     <= tone_high_next;
      tone_att      <= tone_att_next;
      noise_counter <= noise_counter_next;
      noise_period  <= noise_period_next;
      noise_mode    <= noise_mode_next;
      noise_phase   <= noise_phase_next;
      lfsr          <= lfsr_next;
      noise_on      <= noise_on_next;
      noise_att     <= noise_att_next;
    end
  end

  // gated channel levels, captured on the tick
  always_ff @(posedge clk) begin
    if (rst) begin
      mix_valid <= 1'b0;
    end else if (do_tick) begin
      mix_valid <= 1'b1;
    end else if (out_ready) begin
      mix_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_tick) begin
      for (int i = 0; i < 3; i++) begin
        mix_level[i] <= tone_high_next[i] ? LEVELS[tone_att[i]] : '0;
      end
      mix_level[3] <= noise_on_next ? LEVELS[noise_att] : '0;
    end
  end

  assign mix_sum = 15'(mix_level[0]) + 15'(mix_level[1]) +
                   15'(mix_level[2]) + 15'(mix_level[3]);
  assign sample  = (mix_sum > 15'(psg_pkg::SAMPLE_LIMIT)) ?
                   14'(psg_pkg::SAMPLE_LIMIT) : mix_sum[13:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (mix_valid && out_ready) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mix_valid && out_ready) m_axis_tdata <= {2'b00, sample};
  end

endmodule

FILE: sv/psg_three_tone_one_noise_top.sv
// A tick item passes through the command queue, the mixer register and the output register before its sample shows.
// Throughput: one item per cycle unless the output stalls; the two-entry command queue and the output register
// let input and output stall on their own.
// Write items give no result and retire without waiting for the output side.
// Reset (rst, synchronous): all channels silent, tone periods zero, shift register 0x8000.
module psg_three_tone_one_noise_top #(
  parameter int unsigned COUNT_STEP    = psg_pkg::COUNT_STEP,
  parameter int unsigned LOUDEST_LEVEL = psg_pkg::LOUDEST_LEVEL
) (
  input  logic        clk,
  input  logic        rst,
  // input item stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data
  input  logic [1:0]  s_axis_tuser,   // [0] req_type, [1] port_select
  // sample stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [13:0] sample, [15:14] zero
);

  logic          push;
  psg_pkg::cmd_t push_cmd;
  logic          full;
  logic          head_valid;
  psg_pkg::cmd_t head_cmd;
  logic          pop;

  // Input is taken whenever the queue has a free slot; stereo writes are
  // accepted and dropped without using a slot.
  assign s_axis_tready = !full;

  psg_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .push          (push),
    .cmd           (push_cmd)
  );

  psg_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  // Back end: a write updates the registers and retires; a tick steps the generators,
  // latches the four gated levels, and the next stage sums and saturates
  // into the output register.
  psg_back #(
    .COUNT_STEP    (COUNT_STEP),
    .LOUDEST_LEVEL (LOUDEST_LEVEL)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (head_valid),
    .head_cmd      (head_cmd),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

FILE: sv/psg_chk.sv
// Port-level checker for the sound generator, bound to the top level.
`include "psg_three_tone_one_noise_top_assert.svh"

module psg_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [7:0]  s_axis_tdata,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  `PSG_ASSERT_ALWAYS(a_rst_out_idle, clk, rst, !m_axis_tvalid, "output valid after reset")
  `PSG_ASSERT_ALWAYS(a_rst_in_ready, clk, rst, s_axis_tready, "input not ready after reset")
  `PSG_ASSERT_NOW(a_sample_range, clk, rst, m_axis_tvalid, m_axis_tdata <= 16'(psg_pkg::SAMPLE_MAX), "sample above full scale")
  `PSG_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled sample changed")

endmodule

bind psg_three_tone_one_noise_top psg_chk u_chk (.*);

FILE: test/psg_sample_checker.sv
// Stream monitor and sample predictor for the sound generator.
module psg_sample_checker
  import psg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data
  input  logic [1:0]  s_axis_tuser,   // [0] req_type, [1] port_select
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,   // [13:0] sample, [15:14] zero
  output int          fail_count,
  output int          pending
);

  localparam int REPORT_LIMIT = 10;

  // Predicted generator state.
  logic [2:0]  cur_reg;
  logic [9:0]  tone_per [3];
  int          tone_cnt [3];
  logic        tone_out [3];
  logic [3:0]  tone_att [3];
  int          noise_cnt;
  logic [9:0]  noise_per;
  logic [2:0]  noise_ctrl;
  logic        noise_phase;
  logic [15:0] lfsr;
  logic        noise_out;
  logic [3:0]  noise_att;

  logic [SAMPLE_W-1:0] predicted_samples [$];

  initial fail_count = 0;

  function automatic void log_failure(string msg);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) $display("%0t: %s", $realtime, msg);
  endfunction

  function automatic void clear_generator();
    cur_reg = REG_TONE1_ATT;
    for (int i = 0; i < 3; i++) begin
      tone_per[i] = '0;
      tone_cnt[i] = 0;
      tone_out[i] = 1'b1;
      tone_att[i] = 4'hF;
    end
    noise_cnt   = 0;
    noise_per   = NOISE_PERIOD_16;
    noise_ctrl  = '0;
    noise_phase = 1'b1;
    lfsr        = LFSR_SEED;
    noise_out   = 1'b0;
    noise_att   = 4'hF;
  endfunction

  // 2 dB per step, attenuation 15 is silence.
  function automatic int unsigned volume(logic [3:0] att);
    longint unsigned prod;
    if (att == 4'hF) return 0;
    prod = longint'(LOUDEST_LEVEL) * longint'(ATT_Q16[att]) + 64'd32768;
    return 32'(prod >> 16);
  endfunction

  function automatic void write_register(logic [7:0] d);
    logic [2:0] r;
    if (d[7]) cur_reg = d[6:4];
    r = cur_reg;
    case (r) inside
      REG_TONE0_PERIOD, REG_TONE1_PERIOD, REG_TONE2_PERIOD: begin
        // latch byte sets the low nibble, data byte the upper six bits
        if (d[7]) tone_per[r[2:1]][3:0] = d[3:0];
        else tone_per[r[2:1]][9:4] = d[5:0];
        if (r == REG_TONE2_PERIOD && noise_ctrl[1:0] == NOISE_RATE_TONE2)
          noise_per = tone_per[2];
      end
      REG_NOISE_CTRL: begin
        noise_ctrl = d[2:0];
        lfsr       = LFSR_SEED;
        noise_out  = 1'b0;
        case (d[1:0])
          NOISE_RATE_16: noise_per = NOISE_PERIOD_16;
          NOISE_RATE_32: noise_per = NOISE_PERIOD_32;
          NOISE_RATE_64: noise_per = NOISE_PERIOD_64;
          default:       noise_per = tone_per[2];
        endcase
      end
      REG_NOISE_ATT: noise_att = d[3:0];
      default: tone_att[r[2:1]] = d[3:0];
    endcase
  endfunction

  function automatic logic [SAMPLE_W-1:0] next_sample();
    int unsigned mix;
    logic        fb;
    mix = 0;
    for (int i = 0; i < 3; i++) begin
      tone_cnt[i] -= int'(COUNT_STEP);
      if (tone_cnt[i] <= 0) begin
        tone_cnt[i] = int'(tone_per[i]);
        tone_out[i] = !tone_out[i];
      end
    end
    noise_cnt -= int'(COUNT_STEP);
    if (noise_cnt <= 0) begin
      noise_cnt   = int'(noise_per);
      noise_phase = !noise_phase;
      if (noise_phase) begin
        noise_out = lfsr[0];
        fb        = noise_ctrl[2] ? (lfsr[0] ^ lfsr[3]) : lfsr[0];
        lfsr      = {fb, lfsr[15:1]};
      end
    end
    for (int i = 0; i < 3; i++)
      if (tone_out[i]) mix += volume(tone_att[i]);
    if (noise_out) mix += volume(noise_att);
    if (mix > SAMPLE_LIMIT) mix = SAMPLE_LIMIT;
    return SAMPLE_W'(mix);
  endfunction

  always @(posedge clk) begin
    logic [SAMPLE_W-1:0] want;
    if (rst) begin
      clear_generator();
      predicted_samples.delete();
    end else begin
      // input first, so a same-edge result could still find its prediction
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser[0] == REQ_TICK)
          predicted_samples.push_back(next_sample());
        else if (s_axis_tuser[1] == PORT_TONE)
          write_register(s_axis_tdata);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (predicted_samples.size() == 0) begin
          log_failure($sformatf("unexpected sample, tdata %h", m_axis_tdata));
        end else begin
          want = predicted_samples.pop_front();
          if (m_axis_tdata !== {2'b00, want})
            log_failure($sformatf("sample mismatch: expected %0d, got %0d (tdata %h)",
                                  want, m_axis_tdata[SAMPLE_W-1:0], m_axis_tdata));
        end
      end
    end
    pending <= predicted_samples.size();
  end

endmodule

FILE: test/testbench.sv
// Top of the sound generator bench: clock, reset, item stimulus and verdict.
module testbench;
  import psg_pkg::*;

  localparam int RANDOM_ITEMS    = 400;
  localparam int CALM_TAIL       = 80;      // final items run with no idling
  localparam int HOLD_OFF_CYCLES = 300;     // long sample-side stall
  localparam int DRAIN_CYCLES    = 20;
  localparam int TIMEOUT_CYCLES  = 200000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [7:0] data
  logic [1:0]  s_axis_tuser = '0;   // [0] req_type, [1] port_select
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b1;
  logic [15:0] m_axis_tdata;        // [13:0] sample, [15:14] zero

  // Idle controls shared between the two sides.
  logic tx_idle_on  = 1'b0;
  logic rx_idle_on  = 1'b0;
  logic hold_off_go = 1'b0;
  logic hold_off_done = 1'b0;

  int fail_count;
  int pending;
  int items_sent = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  psg_three_tone_one_noise_top dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  psg_sample_checker sample_check (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  // Offer one item and hold it until accepted. An optional idle burst comes first;
  // valid stays high between back-to-back items.
  task automatic send_item(logic kind, logic port, logic [7:0] d);
    if (tx_idle_on && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= {port, kind};
    s_axis_tdata  <= d;
    do @(posedge clk); while (!s_axis_tready);
    // stereo-port writes do nothing, so they are not counted
    if (!(kind == REQ_WRITE && port == PORT_STEREO)) items_sent++;
  endtask

  function automatic logic [7:0] latch_byte(logic [2:0] r, logic [3:0] v);
    return {1'b1, r, v};
  endfunction

  // Tick with junk in the ignored fields.
  task automatic random_tick();
    send_item(REQ_TICK, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
  endtask

  // One register update, biased toward short periods so the tones toggle often.
  task automatic random_write();
    int          pick;
    logic [2:0]  r;
    logic [5:0]  upper;
    pick = $urandom_range(0, 99);
    r    = 3'($urandom_range(0, 2) * 2);
    if (pick < 35) begin
      upper = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63))
                                          : 6'($urandom_range(0, 3));
      send_item(REQ_WRITE, PORT_TONE, latch_byte(r, 4'($urandom_range(0, 15))));
      send_item(REQ_WRITE, PORT_TONE, {1'b0, 1'($urandom_range(0, 1)), upper});
    end else if (pick < 65) begin
      send_item(REQ_WRITE, PORT_TONE, latch_byte(3'($urandom_range(0, 3) * 2 + 1),
                                                 4'($urandom_range(0, 15))));
    end else if (pick < 73) begin
      // data byte to whatever register is latched
      send_item(REQ_WRITE, PORT_TONE, 8'($urandom_range(0, 127)));
    end else if (pick < 83) begin
      // noise control: tone-2 rate is favored since it makes noise audible quickly
      send_item(REQ_WRITE, PORT_TONE,
                latch_byte(REG_NOISE_CTRL, {1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                            ($urandom_range(0, 1) == 0) ? NOISE_RATE_TONE2
                                                : 2'($urandom_range(0, 3))}));
    end else if (pick < 93) begin
      send_item(REQ_WRITE, PORT_TONE, 8'($urandom_range(0, 255)));
    end else begin
      send_item(REQ_WRITE, PORT_STEREO, 8'($urandom_range(0, 255)));
    end
  endtask

  // Sample side: random stalls, plus one long hold-off that backs up the block.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_go && !hold_off_done) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        m_axis_tready <= 1'b1;
        hold_off_done = 1'b1;
      end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst        <= 1'b0;
    tx_idle_on <= 1'b1;
    rx_idle_on <= 1'b1;

    // Directed part.
    // Tick right after reset: everything silent, port and data must be ignored.
    send_item(REQ_TICK, PORT_STEREO, 8'hFF);
    send_item(REQ_WRITE, PORT_TONE, latch_byte(REG_TONE0_ATT, 4'hF));
    send_item(REQ_WRITE, PORT_TONE, 8'h00);            // data byte to an attenuation
    send_item(REQ_WRITE, PORT_TONE, latch_byte(REG_TONE1_ATT, 4'h7));
    send_item(REQ_WRITE, PORT_TONE, latch_byte(REG_TONE2_ATT, 4'h0));
    send_item(REQ_WRITE, PORT_TONE, latch_byte(REG_NOISE_ATT, 4'h0));
    // stereo port: would silence tone 0 if it were not ignored
    send_item(REQ_WRITE, PORT_STEREO, latch_byte(REG_TONE0_ATT, 4'hF));
    // zero period: tone 0 toggles on every tick
    send_item(REQ_WRITE, PORT_TONE, latch_byte(REG_TONE0_PERIOD, 4'h0));
    send_item(REQ_TICK, PORT_TONE, 8'h00);
    send_item(REQ_TICK, PORT_TONE, 8'h00);
    send_item(REQ_WRITE, PORT_TONE, latch_byte(REG_TONE1_PERIOD, 4'h3));
    send_item(REQ_WRITE, PORT_TONE, 8'h00);
    // longest period on tone 2
    send_item(REQ_WRITE, PORT_TONE, latch_byte(REG_TONE2_PERIOD, 4'hF));
    send_item(REQ_WRITE, PORT_TONE, 8'h3F);
    // white noise clocked by tone 2, then a tone-2 update that the noise must follow
    send_item(REQ_WRITE, PORT_TONE,
              latch_byte(REG_NOISE_CTRL, {1'b0, 1'b1, NOISE_RATE_TONE2}));
    send_item(REQ_WRITE, PORT_TONE, latch_byte(REG_TONE2_PERIOD, 4'h4));
    send_item(REQ_WRITE, PORT_TONE, 8'h40);            // bit 6 of a data byte is dropped
    repeat (6) send_item(REQ_TICK, PORT_TONE, 8'h00);
    send_item(REQ_WRITE, PORT_TONE,
              latch_byte(REG_NOISE_CTRL, {1'b0, 1'b0, NOISE_RATE_16}));

    // Random part. It opens with a run of ticks against the long hold-off.
    items_sent  = 0;
    hold_off_go <= 1'b1;
    repeat (30) random_tick();
    while (items_sent < RANDOM_ITEMS) begin
      if (items_sent < RANDOM_ITEMS - CALM_TAIL) begin
        tx_idle_on <= ($urandom_range(0, 3) != 0);
        rx_idle_on <= ($urandom_range(0, 3) != 0);
      end else begin
        tx_idle_on <= 1'b0;
        rx_idle_on <= 1'b0;
      end
      // a few register updates, then a run of ticks to hear them
      repeat ($urandom_range(1, 6)) random_write();
      repeat (($urandom_range(0, 9) == 0) ? 120 : $urandom_range(4, 40)) random_tick();
    end

    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  // Watchdog.
  initial begin
    #(TIMEOUT_CYCLES * 10);
    $display("simulation failed");
    $finish;
  end

endmodule
